// File: hw/rtl/acpi_pm_gpe_hotplug_regs_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power-management register block
// Concurrent checks on clock with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef ACPI_PM_GPE_HOTPLUG_REGS_UNIT_MACROS_SVH
`define ACPI_PM_GPE_HOTPLUG_REGS_UNIT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define APGHR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define APGHR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/agpr_pkg.sv
// ----------------------------------------------------------------------------
// agpr_pkg
// Types, codes and constants shared by the PM1 / GPE0 / hotplug register block.
// ----------------------------------------------------------------------------
`default_nettype none

package agpr_pkg;

   localparam int GPE_HALF_BYTES = 2;
   localparam int SLOTS          = 32;
   localparam int GPE_IDX_W      = (GPE_HALF_BYTES > 1) ? $clog2(GPE_HALF_BYTES) : 1;
   localparam int SLOT_IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [1:0] {
      OP_READ       = 2'd0,
      OP_WRITE      = 2'd1,
      OP_HOT_ADD    = 2'd2,
      OP_HOT_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RGN_PM1_CTRL = 2'd0,
      RGN_GPE_STS  = 2'd1,
      RGN_GPE_EN   = 2'd2,
      RGN_HOTPLUG  = 2'd3
   } region_type;

   typedef enum logic [1:0] {
      SLEEP_NONE     = 2'd0,
      SLEEP_S3       = 2'd1,
      SLEEP_SHUTDOWN = 2'd2
   } sleep_type;

   typedef enum logic [1:0] {
      ACT_NONE      = 2'd0,
      ACT_POWER_ON  = 2'd1,
      ACT_POWER_OFF = 2'd2
   } slot_act_type;

   // PM1 control bits
   localparam logic [15:0] PM1_RESET     = 16'h0001;
   localparam logic [15:0] PM1_GBL_RLS   = 16'h0004;
   localparam logic [15:0] PM1_SLP_EN    = 16'h2000;
   localparam logic [15:0] PM1_TYPE_MASK = 16'h1C00;
   localparam logic [15:0] PM1_TYPE_S3   = 16'h1400;
   localparam logic [15:0] PM1_TYPE_S4   = 16'h1800;
   localparam logic [15:0] PM1_TYPE_S5   = 16'h1C00;

   // Byte offsets
   localparam logic [5:0] PM1_OFF_LOW      = 6'd0;
   localparam logic [5:0] PM1_OFF_HIGH     = 6'd1;
   localparam logic [5:0] GPE_OFF_HP_BYTE  = 6'd0;
   localparam logic [5:0] HP_OFF_EVENT     = 6'd0;
   localparam logic [5:0] HP_OFF_SLOT      = 6'd1;
   localparam logic [5:0] HP_OFF_SLOT_BASE = 6'd2;

   // Hotplug GPE is bit 3 of GPE byte 0
   localparam int HP_GPE_BIT = 3;

   localparam logic [1:0] EVT_CLEAR  = 2'd0;
   localparam logic [1:0] EVT_ADD    = 2'd0;
   localparam logic [1:0] EVT_REMOVE = 2'd3;

   localparam logic [7:0] SLOT_PRESENT_RD = 8'h0F;
   localparam logic [7:0] EJECT_CODE      = 8'h01;

   typedef struct packed {
      logic [1:0]  operation;
      logic [1:0]  region;
      logic [5:0]  offset;
      logic        word_access;
      logic [15:0] data;
      logic [4:0]  slot;
      logic        slot_ok;
   } req_item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        sci_line;
      logic [1:0]  sleep_request;
      logic [1:0]  slot_action;
      logic [4:0]  action_slot;
   } rsp_item_type;

   function automatic sleep_type sleep_decode(input logic [15:0] value);
      sleep_type   req;
      logic [15:0] typ;
      typ = value & PM1_TYPE_MASK;
      req = SLEEP_NONE;
      if ((value & PM1_SLP_EN) != 16'h0000) begin
         if (typ == PM1_TYPE_S3) begin
            req = SLEEP_S3;
         end else if (typ == PM1_TYPE_S4 || typ == PM1_TYPE_S5) begin
            req = SLEEP_SHUTDOWN;
         end
      end
      return req;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/agpr_req_if.sv
// ----------------------------------------------------------------------------
// agpr_req_if
// Request channel: bus accesses and hotplug events, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface agpr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [1:0]  region;
   logic [5:0]  offset;
   logic        word_access;
   logic [15:0] data;
   logic [4:0]  slot;
   logic        slot_ok;

   modport source (
      output valid, operation, region, offset, word_access, data, slot, slot_ok,
      input  ready
   );

   modport sink (
      input  valid, operation, region, offset, word_access, data, slot, slot_ok,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/agpr_rsp_if.sv
// ----------------------------------------------------------------------------
// agpr_rsp_if
// Response channel: read data, SCI level and power actions, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface agpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        sci_line;
   logic [1:0]  sleep_request;
   logic [1:0]  slot_action;
   logic [4:0]  action_slot;

   modport source (
      output valid, read_data, sci_line, sleep_request, slot_action, action_slot,
      input  ready
   );

   modport sink (
      input  valid, read_data, sci_line, sleep_request, slot_action, action_slot,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/agpr_in_stage.sv
// ----------------------------------------------------------------------------
// agpr_in_stage
// Input register: captures one request item, frees as the item moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module agpr_in_stage import agpr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   agpr_req_if.sink      req_chan,
   input  logic          take,
   output logic          in_valid,
   output req_item_type  item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.operation   = req_chan.operation;
      item_in.region      = req_chan.region;
      item_in.offset      = req_chan.offset;
      item_in.word_access = req_chan.word_access;
      item_in.data        = req_chan.data;
      item_in.slot        = req_chan.slot;
      item_in.slot_ok     = req_chan.slot_ok;
      valid_in            = accept || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign in_valid = valid_ff;
   assign item     = item_ff;

endmodule

`default_nettype wire

// File: hw/rtl/agpr_core.sv
// ----------------------------------------------------------------------------
// agpr_core
// Register state and the per-item read/modify/write decode.
// ----------------------------------------------------------------------------
`default_nettype none

module agpr_core import agpr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [31:0]   csr_write_data,
   input  logic          take,
   input  req_item_type  item,
   output rsp_item_type  result
);

   logic [15:0]      pm1_ctrl_ff, pm1_ctrl_in;
   logic [7:0]       gpe_status_ff [GPE_HALF_BYTES];
   logic [7:0]       gpe_status_in [GPE_HALF_BYTES];
   logic [7:0]       gpe_enable_ff [GPE_HALF_BYTES];
   logic [7:0]       gpe_enable_in [GPE_HALF_BYTES];
   logic             sci_flag_ff, sci_flag_in;
   logic             sci_level_ff, sci_level_in;
   logic [1:0]       plug_event_ff, plug_event_in;
   logic [4:0]       plug_slot_ff, plug_slot_in;
   logic [SLOTS-1:0] slot_present_ff, slot_present_in;

   logic                  gpe_hit;
   logic [GPE_IDX_W-1:0]  gpe_idx;
   logic [5:0]            slot_off;
   logic                  slot_hit;
   logic [SLOT_IDX_W-1:0] slot_idx;
   logic                  evt_hit;
   logic [7:0]            byte_val;
   logic [15:0]           pm1_vis;
   logic [15:0]           rd;
   sleep_type             sleep_req;
   slot_act_type          action;
   logic [4:0]            action_slot;

   assign gpe_hit  = item.offset < 6'(GPE_HALF_BYTES);
   assign gpe_idx  = item.offset[GPE_IDX_W-1:0];
   assign slot_off = item.offset - HP_OFF_SLOT_BASE;
   assign slot_hit = (item.offset >= HP_OFF_SLOT_BASE) && (slot_off < 6'(SLOTS));
   assign slot_idx = slot_off[SLOT_IDX_W-1:0];
   assign evt_hit  = item.slot_ok && ({1'b0, item.slot} < 6'(SLOTS));
   assign byte_val = item.data[7:0];
   assign pm1_vis  = pm1_ctrl_ff & ~(PM1_GBL_RLS | PM1_SLP_EN);

   always_comb begin
      pm1_ctrl_in     = pm1_ctrl_ff;
      gpe_status_in   = gpe_status_ff;
      gpe_enable_in   = gpe_enable_ff;
      sci_flag_in     = sci_flag_ff;
      sci_level_in    = sci_level_ff;
      plug_event_in   = plug_event_ff;
      plug_slot_in    = plug_slot_ff;
      slot_present_in = slot_present_ff;
      rd              = 16'h0000;
      sleep_req       = SLEEP_NONE;
      action          = ACT_NONE;
      action_slot     = 5'd0;

      unique case (item.operation) inside
         OP_READ: begin
            unique case (item.region)
               RGN_PM1_CTRL: begin
                  if (item.word_access) begin
                     if (item.offset == PM1_OFF_LOW) rd = pm1_vis;
                  end else if (item.offset == PM1_OFF_LOW) begin
                     rd = {8'h00, pm1_vis[7:0]};
                  end else if (item.offset == PM1_OFF_HIGH) begin
                     rd = {8'h00, pm1_vis[15:8]};
                  end
               end
               RGN_GPE_STS: begin
                  if (gpe_hit) rd = {8'h00, gpe_status_ff[gpe_idx]};
               end
               RGN_GPE_EN: begin
                  if (gpe_hit) rd = {8'h00, gpe_enable_ff[gpe_idx]};
               end
               RGN_HOTPLUG: begin
                  if (item.offset == HP_OFF_EVENT) begin
                     rd = {14'h0000, plug_event_ff};
                  end else if (item.offset == HP_OFF_SLOT) begin
                     rd = {11'h000, plug_slot_ff};
                  end else if (slot_hit && slot_present_ff[slot_idx]) begin
                     rd = {8'h00, SLOT_PRESENT_RD};
                  end
               end
            endcase
         end
         OP_WRITE: begin
            unique case (item.region)
               RGN_PM1_CTRL: begin
                  if (item.word_access) begin
                     if (item.offset == PM1_OFF_LOW) begin
                        pm1_ctrl_in = item.data & ~PM1_SLP_EN;
                        sleep_req   = sleep_decode(item.data);
                     end
                  end else if (item.offset == PM1_OFF_LOW) begin
                     pm1_ctrl_in = {pm1_ctrl_ff[15:8], byte_val};
                  end else if (item.offset == PM1_OFF_HIGH) begin
                     // SLP_EN is a strobe: decode it, never store it
                     pm1_ctrl_in = {byte_val, pm1_ctrl_ff[7:0]} & ~PM1_SLP_EN;
                     sleep_req   = sleep_decode({byte_val, 8'h00});
                  end
               end
               RGN_GPE_STS: begin
                  if (gpe_hit) begin
                     gpe_status_in[gpe_idx] = gpe_status_ff[gpe_idx] & ~byte_val;
                     // drop the line but keep the asserted flag
                     if (sci_flag_ff && gpe_status_ff[0][HP_GPE_BIT] &&
                         !gpe_status_in[0][HP_GPE_BIT]) begin
                        sci_level_in = 1'b0;
                     end
                  end
               end
               RGN_GPE_EN: begin
                  if (gpe_hit) begin
                     gpe_enable_in[gpe_idx] = byte_val;
                     if (sci_flag_ff && item.offset == GPE_OFF_HP_BYTE &&
                         !byte_val[HP_GPE_BIT]) begin
                        sci_flag_in  = 1'b0;
                        sci_level_in = 1'b0;
                     end
                  end
               end
               RGN_HOTPLUG: begin
                  if (slot_hit && byte_val == EJECT_CODE) begin
                     slot_present_in[slot_idx] = 1'b0;
                     plug_event_in             = EVT_CLEAR;
                     plug_slot_in              = 5'd0;
                     action                    = ACT_POWER_OFF;
                     action_slot               = slot_off[4:0];
                  end
               end
            endcase
         end
         OP_HOT_ADD, OP_HOT_REMOVE: begin
            if (evt_hit) begin
               plug_slot_in = item.slot;
               if (item.operation == OP_HOT_ADD) begin
                  plug_event_in = EVT_ADD;
                  slot_present_in[item.slot[SLOT_IDX_W-1:0]] = 1'b1;
                  action      = ACT_POWER_ON;
                  action_slot = item.slot;
               end else begin
                  plug_event_in = EVT_REMOVE;
               end
               // raise the SCI once while the hotplug GPE is enabled and clear
               if (!gpe_status_ff[0][HP_GPE_BIT] && gpe_enable_ff[0][HP_GPE_BIT]) begin
                  gpe_status_in[0][HP_GPE_BIT] = 1'b1;
                  sci_flag_in  = 1'b1;
                  sci_level_in = 1'b1;
               end
            end
         end
      endcase

      result.read_data     = rd;
      result.sci_line      = sci_level_in;
      result.sleep_request = sleep_req;
      result.slot_action   = action;
      result.action_slot   = action_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm1_ctrl_ff     <= PM1_RESET;
         gpe_status_ff   <= '{default: 8'h00};
         gpe_enable_ff   <= '{default: 8'h00};
         sci_flag_ff     <= 1'b0;
         sci_level_ff    <= 1'b0;
         plug_event_ff   <= EVT_CLEAR;
         plug_slot_ff    <= 5'd0;
         slot_present_ff <= '0;
      end else begin
         if (take) begin
            pm1_ctrl_ff     <= pm1_ctrl_in;
            gpe_status_ff   <= gpe_status_in;
            gpe_enable_ff   <= gpe_enable_in;
            sci_flag_ff     <= sci_flag_in;
            sci_level_ff    <= sci_level_in;
            plug_event_ff   <= plug_event_in;
            plug_slot_ff    <= plug_slot_in;
         end
         if (csr_write_enable) begin
            slot_present_ff <= csr_write_data[SLOTS-1:0];
         end else if (take) begin
            slot_present_ff <= slot_present_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/agpr_out_stage.sv
// ----------------------------------------------------------------------------
// agpr_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module agpr_out_stage import agpr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  rsp_item_type  result,
   output logic          take,
   agpr_rsp_if.source    rsp_chan
);

   logic         valid_ff, valid_in;
   rsp_item_type result_ff;

   // advance whenever the result register is empty or being drained
   assign take     = in_valid && (!valid_ff || rsp_chan.ready);
   assign valid_in = take || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.read_data     = result_ff.read_data;
   assign rsp_chan.sci_line      = result_ff.sci_line;
   assign rsp_chan.sleep_request = result_ff.sleep_request;
   assign rsp_chan.slot_action   = result_ff.slot_action;
   assign rsp_chan.action_slot   = result_ff.action_slot;

endmodule

`default_nettype wire

// File: hw/rtl/acpi_pm_gpe_hotplug_regs_unit.sv
// Path: an accepted request is registered in the input reg, then its result in the
//   result reg, where it is held until the response sink takes it.
// Throughput: one item per cycle while the response sink is ready; the state update
//   is a combinational read-modify-write between the input and result registers.
// Reset (synchronous, active high): PM1 control = SCI_EN, GPE, SCI, event,
//   slot and presence registers cleared; both stages empty.
// ----------------------------------------------------------------------------
// acpi_pm_gpe_hotplug_regs_unit
// PM1 control, GPE0 status/enable and hotplug controller register block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "acpi_pm_gpe_hotplug_regs_unit_macros.svh"

module acpi_pm_gpe_hotplug_regs_unit import agpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   agpr_req_if.sink    req_chan,
   agpr_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic         in_valid;
   logic         take;
   req_item_type item;
   rsp_item_type result;

   agpr_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .in_valid (in_valid),
      .item     (item)
   );

   agpr_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .take             (take),
      .item             (item),
      .result           (result)
   );

   agpr_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .result   (result),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

   `APGHR_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_chan.valid && req_chan.ready, in_valid, "accepted item missing from input stage")
   `APGHR_ASSERT_NEXT(a_take_fills_result, clock, reset, take, rsp_chan.valid, "advanced item missing from result stage")
   `APGHR_ASSERT_IMPL(a_no_action_no_slot, clock, reset, rsp_chan.valid && rsp_chan.slot_action == ACT_NONE, rsp_chan.action_slot == 5'd0, "action slot set without a slot action")
   `APGHR_ASSERT_IMPL(a_sleep_not_on_read, clock, reset, rsp_chan.valid && rsp_chan.sleep_request != SLEEP_NONE, rsp_chan.read_data == 16'h0000 && rsp_chan.slot_action == ACT_NONE, "sleep request mixed with read data or slot action")

endmodule

`default_nettype wire
